### src/near_field_beam_phase_generator_top_defines.svh
// Assertion macros used by the asserting file of the block.
`ifndef NEAR_FIELD_BEAM_PHASE_GENERATOR_TOP_DEFINES_SVH
`define NEAR_FIELD_BEAM_PHASE_GENERATOR_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define NFBP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define NFBP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/nfbp_pkg.sv
package nfbp_pkg;

	// Register indexes of the configuration port
	typedef enum logic [1:0] {
		REG_TARGET_X = 2'd0,
		REG_TARGET_Y = 2'd1,
		REG_TARGET_Z = 2'd2
	} reg_index_t;

	localparam int COORD_W     = 30;  // target coordinate width
	localparam int FRAC_W      = 12;  // fraction bits of a wavelength
	localparam int PITCH_SH    = 11;  // half-wavelength pitch, 2048 units
	localparam int SQ_W        = 60;  // width of one squared difference
	localparam int SUM_W       = 62;  // width of the sum of three squares
	localparam int ROOT_STEPS  = 31;  // root bits, one per cell
	localparam int SINE_STAGES = 7;   // depth of a quarter-sine lane

	// Q30 Taylor coefficients of sin(pi/2 x)
	localparam logic [31:0] C1 = 32'd1686629713;
	localparam logic [31:0] C3 = 32'd693598669;
	localparam logic [31:0] C5 = 32'd85569306;
	localparam logic [31:0] C7 = 32'd5026995;
	localparam logic [31:0] C9 = 32'd172272;

endpackage

### src/near_field_beam_phase_generator_top.sv
// Near-field focusing phase generator. Each input word names one array element by row and
// column; the block returns its focusing phase toward the configured target together with the
// Q1.14-style cosine and sine weights. One word enters per clock while in_stall is low, and results
// leave in order, one per input, through 43 register stages: three stages form the squared
// distance, a chain of 31 square-root cells resolves one root bit each, one stage scales the phase
// and two seven-stage quarter-sine lanes plus an output register build the weights. Pipeline stages
// only stop when a result waits downstream and every stage ahead of them is full, so bubbles close
// up under stall. Target registers go through cfg_we/cfg_index/cfg_data; the user must write them
// only while the pipeline is empty, as the block does not enforce it.
`include "near_field_beam_phase_generator_top_defines.svh"

module near_field_beam_phase_generator_top #(
	parameter int GRID_ROWS   = 64,
	parameter int GRID_COLS   = 64,
	parameter int PHASE_BITS  = 12,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [29:0]             cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [5:0]              elem_row,
	input  logic [5:0]              elem_col,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [PHASE_BITS-1:0]   phase_frac,
	output logic signed [WEIGHT_BITS-1:0] weight_real,
	output logic signed [WEIGHT_BITS-1:0] weight_imag
);
	import nfbp_pkg::*;

	localparam int ROOT_FIRST = 3;
	localparam int PH_STAGE   = ROOT_FIRST + ROOT_STEPS;
	localparam int SINE_FIRST = PH_STAGE + 1;
	localparam int OUT_STAGE  = SINE_FIRST + SINE_STAGES;
	localparam int DEPTH      = OUT_STAGE + 1;
	localparam int ROW_MAX    = GRID_ROWS - 1;
	localparam int COL_MAX    = GRID_COLS - 1;
	localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

	logic signed [COORD_W-1:0] tx_q, ty_q, tz_q;
	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] adv;

	// Write target registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q <= '0;
			ty_q <= '0;
			tz_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TARGET_X: tx_q <= cfg_data;
				REG_TARGET_Y: ty_q <= cfg_data;
				REG_TARGET_Z: tz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage advances unless it and every stage after it hold a word and the output stalls
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_adv
			assign adv[gi] = !out_stall || !(&vld_q[DEPTH-1:gi]);
		end
	endgenerate

	assign in_stall  = !adv[0];
	assign out_valid = vld_q[DEPTH-1];

	// Track word occupancy stage by stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int i = 1; i < DEPTH; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Clamp indexes to the grid and form coordinate differences
	logic [5:0]  row_c, col_c;
	logic [30:0] dx, dy, dz;
	logic [29:0] ax_s1, ay_s1, az_s1;

	assign row_c = (11'(elem_row) > 11'(ROW_MAX)) ? 6'(ROW_MAX) : elem_row;
	assign col_c = (11'(elem_col) > 11'(COL_MAX)) ? 6'(COL_MAX) : elem_col;
	assign dx = {tx_q[COORD_W-1], tx_q} - {14'd0, col_c, 11'd0};
	assign dy = {ty_q[COORD_W-1], ty_q} - {14'd0, row_c, 11'd0};
	assign dz = {tz_q[COORD_W-1], tz_q};

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ax_s1 <= dx[30] ? 30'(-dx) : dx[29:0];
			ay_s1 <= dy[30] ? 30'(-dy) : dy[29:0];
			az_s1 <= dz[30] ? 30'(-dz) : dz[29:0];
		end
	end

	// Square the differences, then sum them
	logic [SQ_W-1:0]  sqx_s2, sqy_s2, sqz_s2;
	logic [SUM_W-1:0] sum_s3;

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sqx_s2 <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
			sqy_s2 <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
			sqz_s2 <= SQ_W'(az_s1) * SQ_W'(az_s1);
		end
		if (adv[2]) begin
			sum_s3 <= SUM_W'(sqx_s2) + SUM_W'(sqy_s2) + SUM_W'(sqz_s2);
		end
	end

	// Resolve the root one bit per cell
	logic [SUM_W-1:0] rem_c  [ROOT_STEPS];
	logic [SUM_W-1:0] root_c [ROOT_STEPS];

	generate
		for (gi = 0; gi < ROOT_STEPS; gi++) begin : g_root
			if (gi == 0) begin : g_head
				nfbp_root_cell #(.SHIFT(2 * (ROOT_STEPS - 1))) u_cell (
					.clk     (clk),
					.en      (adv[ROOT_FIRST]),
					.rem_in  (sum_s3),
					.root_in ('0),
					.rem_out (rem_c[0]),
					.root_out(root_c[0])
				);
			end else begin : g_body
				nfbp_root_cell #(.SHIFT(2 * (ROOT_STEPS - 1 - gi))) u_cell (
					.clk     (clk),
					.en      (adv[ROOT_FIRST+gi]),
					.rem_in  (rem_c[gi-1]),
					.root_in (root_c[gi-1]),
					.rem_out (rem_c[gi]),
					.root_out(root_c[gi])
				);
			end
		end
	endgenerate

	// Scale the distance fraction to the phase width
	logic [FRAC_W-1:0]     frac;
	logic [PHASE_BITS-1:0] phase;
	logic [PHASE_BITS-1:0] phase_s4;
	logic [PHASE_BITS-2:0] klo_s4, khi_s4;

	assign frac = root_c[ROOT_STEPS-1][FRAC_W-1:0];

	generate
		if (PHASE_BITS >= FRAC_W) begin : g_up
			assign phase = PHASE_BITS'({{PHASE_BITS{1'b0}}, frac} << (PHASE_BITS - FRAC_W));
		end else begin : g_down
			assign phase = PHASE_BITS'(frac >> (FRAC_W - PHASE_BITS));
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (adv[PH_STAGE]) begin
			phase_s4 <= phase;
			klo_s4   <= (PHASE_BITS-1)'(phase[PHASE_BITS-3:0]);
			khi_s4   <= (PHASE_BITS-1)'(QUARTER - PHASE_BITS'(phase[PHASE_BITS-3:0]));
		end
	end

	// Quarter-sine lanes for the remainder and its complement
	logic [WEIGHT_BITS-1:0] s_lo, s_hi;

	nfbp_sine #(.PHASE_BITS(PHASE_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_sine_lo (
		.clk(clk),
		.en (adv[SINE_FIRST +: SINE_STAGES]),
		.k  (klo_s4),
		.s  (s_lo)
	);

	nfbp_sine #(.PHASE_BITS(PHASE_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_sine_hi (
		.clk(clk),
		.en (adv[SINE_FIRST +: SINE_STAGES]),
		.k  (khi_s4),
		.s  (s_hi)
	);

	// Delay the phase alongside the lanes
	logic [PHASE_BITS-1:0] ph_dly_q [SINE_STAGES];

	always_ff @(posedge clk) begin
		if (adv[SINE_FIRST]) ph_dly_q[0] <= phase_s4;
		for (int i = 1; i < SINE_STAGES; i++) begin
			if (adv[SINE_FIRST+i]) ph_dly_q[i] <= ph_dly_q[i-1];
		end
	end

	// Fold the quadrant into signs and hold the result word
	logic [1:0]             quad;
	logic [WEIGHT_BITS-1:0] cos_w, sin_w;
	logic [PHASE_BITS-1:0]  phase_q;
	logic [WEIGHT_BITS-1:0] real_q, imag_q;

	assign quad = ph_dly_q[SINE_STAGES-1][PHASE_BITS-1:PHASE_BITS-2];

	always_comb begin
		case (quad)
			2'd0: begin
				sin_w = s_lo;
				cos_w = s_hi;
			end
			2'd1: begin
				sin_w = s_hi;
				cos_w = -s_lo;
			end
			2'd2: begin
				sin_w = -s_lo;
				cos_w = -s_hi;
			end
			default: begin
				sin_w = -s_hi;
				cos_w = s_lo;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[OUT_STAGE]) begin
			phase_q <= ph_dly_q[SINE_STAGES-1];
			real_q  <= cos_w;
			imag_q  <= sin_w;
		end
	end

	assign phase_frac  = phase_q;
	assign weight_real = real_q;
	assign weight_imag = imag_q;

	// Input only backs up when the pipeline is full behind a stalled result
	`NFBP_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without cause")
	// First quadrant weights are never negative
	`NFBP_ASSERT(a_quad0_sign, (out_valid && (phase_frac[PHASE_BITS-1:PHASE_BITS-2] == 2'd0)) |-> (!weight_real[WEIGHT_BITS-1] && !weight_imag[WEIGHT_BITS-1]), "negative weight in first quadrant")
	// Nothing leaves the block while reset is asserted
	`NFBP_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "result valid during reset")
endmodule

### src/nfbp_root_cell.sv
module nfbp_root_cell #(
	parameter int SHIFT = 0
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [nfbp_pkg::SUM_W-1:0] rem_in,
	input  logic [nfbp_pkg::SUM_W-1:0] root_in,
	output logic [nfbp_pkg::SUM_W-1:0] rem_out,
	output logic [nfbp_pkg::SUM_W-1:0] root_out
);
	import nfbp_pkg::*;

	localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << SHIFT;

	logic [SUM_W-1:0] trial;
	logic             fits;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] root_q;

	// Try one root bit against the remainder
	assign trial = root_in + BIT;
	assign fits  = rem_in >= trial;

	// Advance the partial root and remainder
	always_ff @(posedge clk) begin
		if (en) begin
			if (fits) begin
				rem_q  <= rem_in - trial;
				root_q <= (root_in >> 1) + BIT;
			end else begin
				rem_q  <= rem_in;
				root_q <= root_in >> 1;
			end
		end
	end

	assign rem_out  = rem_q;
	assign root_out = root_q;
endmodule

### src/nfbp_sine.sv
module nfbp_sine #(
	parameter int PHASE_BITS  = 12,
	parameter int WEIGHT_BITS = 16
) (
	input  logic                              clk,
	input  logic [nfbp_pkg::SINE_STAGES-1:0]  en,
	input  logic [PHASE_BITS-2:0]             k,
	output logic [WEIGHT_BITS-1:0]            s
);
	import nfbp_pkg::*;

	localparam int          XSH = 30 - (PHASE_BITS - 2);
	localparam logic [63:0] AMP = 64'(1) << (WEIGHT_BITS - 2);
	localparam logic [63:0] RND = 64'(1) << 29;

	logic [30:0] x_in;
	logic [61:0] p1;
	logic [62:0] p2, p3, p4, p5, p6;
	logic [63:0] yscaled;
	logic [33:0] s_full;

	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5;
	logic [30:0] x2_s1, x2_s2, x2_s3, x2_s4;
	logic [31:0] t_s2, t_s3, t_s4, t_s5;
	logic [31:0] y_s6;
	logic [WEIGHT_BITS-1:0] s_s7;

	// Scale the index to Q30 and square it
	assign x_in = 31'(k) << XSH;
	assign p1   = 62'(x_in) * 62'(x_in);

	// Horner steps, one product per stage
	assign p2 = 63'(C9) * 63'(x2_s1);
	assign p3 = 63'(t_s2) * 63'(x2_s2);
	assign p4 = 63'(t_s3) * 63'(x2_s3);
	assign p5 = 63'(t_s4) * 63'(x2_s4);
	assign p6 = 63'(t_s5) * 63'(x_s5);

	// Round to the output amplitude and clip at full scale
	assign yscaled = (64'(y_s6) << (WEIGHT_BITS - 2)) + RND;
	assign s_full  = yscaled[63:30];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			x_s1  <= x_in;
			x2_s1 <= p1[60:30];
		end
		if (en[1]) begin
			x_s2  <= x_s1;
			x2_s2 <= x2_s1;
			t_s2  <= C7 - p2[61:30];
		end
		if (en[2]) begin
			x_s3  <= x_s2;
			x2_s3 <= x2_s2;
			t_s3  <= C5 - p3[61:30];
		end
		if (en[3]) begin
			x_s4  <= x_s3;
			x2_s4 <= x2_s3;
			t_s4  <= C3 - p4[61:30];
		end
		if (en[4]) begin
			x_s5 <= x_s4;
			t_s5 <= C1 - p5[61:30];
		end
		if (en[5]) begin
			y_s6 <= p6[61:30];
		end
		if (en[6]) begin
			s_s7 <= (64'(s_full) > AMP) ? WEIGHT_BITS'(AMP) : WEIGHT_BITS'(s_full);
		end
	end

	assign s = s_s7;
endmodule

### test/tb_near_field_beam_phase_generator_top.sv
module tb_near_field_beam_phase_generator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import nfbp_pkg::*;

	localparam int IDLE_LIMIT = 6000;  // cycles with no word moving
	localparam int DRAIN_WAIT = 60;    // a little over the 43-stage pipeline

	typedef struct packed {
		logic [11:0]        phase;
		logic signed [15:0] re;
		logic signed [15:0] im;
	} weight_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [29:0] cfg_data = 30'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [5:0]  elem_row = 6'd0;
	logic [5:0]  elem_col = 6'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [11:0] phase_frac;
	logic signed [15:0] weight_real;
	logic signed [15:0] weight_imag;

	// local copy of the target registers
	logic signed [29:0] tgt_x = '0, tgt_y = '0, tgt_z = '0;

	weight_t pending_weights[$];
	int      n_errors = 0;
	int      n_sent = 0;
	int      n_checked = 0;
	int      n_cfg = 0;
	bit      gaps_on = 1'b1;
	int      hold_request = 0;
	int      hold_left = 0;
	int      idle_cycles = 0;

	near_field_beam_phase_generator_top uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.elem_row(elem_row), .elem_col(elem_col),
		.out_valid(out_valid), .out_stall(out_stall),
		.phase_frac(phase_frac), .weight_real(weight_real), .weight_imag(weight_imag)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// floor square root, one result bit per pass
	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// quarter-wave sine, polynomial in Q30, amplitude 2^14
	function automatic longint unsigned quarter_sin(input logic [10:0] k);
		longint unsigned x, x2, t, y, s;
		x = longint'(k) << 20;
		x2 = (x * x) >> 30;
		t = C9;
		t = C7 - ((t * x2) >> 30);
		t = C5 - ((t * x2) >> 30);
		t = C3 - ((t * x2) >> 30);
		t = C1 - ((t * x2) >> 30);
		y = (t * x) >> 30;
		s = (y * 16384 + (64'd1 << 29)) >> 30;
		if (s > 16384) s = 16384;
		return s;
	endfunction

	function automatic longint unsigned sq_mag(input longint d);
		longint unsigned a;
		a = (d < 0) ? longint'(-d) : d;
		return a * a;
	endfunction

	function automatic weight_t focus_weight(input logic [5:0] row, input logic [5:0] col);
		weight_t w;
		longint dx, dy;
		longint unsigned range_len;
		logic [9:0] r;
		int sn, cs, s_r, s_c;
		dx = longint'(tgt_x) - longint'({col, 11'd0});
		dy = longint'(tgt_y) - longint'({row, 11'd0});
		range_len = root_floor(sq_mag(dx) + sq_mag(dy) + sq_mag(longint'(tgt_z)));
		w.phase = range_len[11:0];
		r = w.phase[9:0];
		s_r = int'(quarter_sin({1'b0, r}));
		s_c = int'(quarter_sin(11'd1024 - r));
		case (w.phase[11:10])
			2'd0: begin sn = s_r;  cs = s_c;  end
			2'd1: begin sn = s_c;  cs = -s_r; end
			2'd2: begin sn = -s_r; cs = -s_c; end
			default: begin sn = -s_c; cs = s_r; end
		endcase
		w.re = cs[15:0];
		w.im = sn[15:0];
		return w;
	endfunction

	task automatic report(input string what, input int got, input int want);
		n_errors++;
		$display("ERROR t=%0t word %0d: %s got %0d want %0d", $realtime, n_checked, what,
			got, want);
	endtask

	// check each result word against the oldest prediction
	always @(posedge clk) begin
		weight_t w;
		if (out_valid && !out_stall) begin
			if (pending_weights.size() == 0) begin
				report("unexpected result, phase", phase_frac, -1);
			end else begin
				w = pending_weights.pop_front();
				if (phase_frac !== w.phase) report("phase_frac", phase_frac, w.phase);
				if (weight_real !== w.re) report("weight_real", weight_real, w.re);
				if (weight_imag !== w.im) report("weight_imag", weight_imag, w.im);
			end
			n_checked++;
		end
	end

	// receiver stalls: random gaps, or a long hold-off on request
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (gaps_on) begin
			out_stall <= ($urandom_range(0, 9) < 3) ?
				1'b1 : ($urandom_range(0, 40) == 0);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on cycles where nothing moves
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("ERROR watchdog: no progress for %0d cycles", IDLE_LIMIT);
			$display("near_field_beam_phase_generator_top verification failed");
			$finish;
		end
	end

	function automatic int pick_gap();
		int p;
		if (!gaps_on) return 0;
		p = $urandom_range(0, 19);
		if (p < 13) return 0;
		if (p < 18) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// offer one element word and record its prediction once accepted
	task automatic send_elem(input logic [5:0] row, input logic [5:0] col);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		elem_row <= row;
		elem_col <= col;
		do @(posedge clk); while (in_stall);
		pending_weights.push_back(focus_weight(row, col));
		n_sent++;
	endtask

	// drop valid, then wait for the pipeline to empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_weights.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_target(input reg_index_t idx, input logic [29:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TARGET_X: tgt_x = val;
			REG_TARGET_Y: tgt_y = val;
			default: tgt_z = val;
		endcase
		n_cfg++;
	endtask

	task automatic set_target(input logic [29:0] x, input logic [29:0] y,
		input logic [29:0] z);
		write_target(REG_TARGET_X, x);
		write_target(REG_TARGET_Y, y);
		write_target(REG_TARGET_Z, z);
	endtask

	// reset targets sit at the array origin
	task automatic test_reset_target();
		send_elem(6'd0, 6'd0);
		send_elem(6'd63, 6'd63);
		send_elem(6'd0, 6'd63);
		send_elem(6'd63, 6'd0);
		send_elem(6'd21, 6'd42);
		drain();
	endtask

	// extreme target coordinates with corner elements
	task automatic test_extreme_targets();
		logic [29:0] tmax, tmin;
		tmax = 30'h1FFF_FFFF;
		tmin = 30'h2000_0000;
		set_target(tmax, tmax, tmax);
		send_elem(6'd0, 6'd0);
		send_elem(6'd63, 6'd63);
		send_elem(6'd42, 6'd21);
		drain();
		set_target(tmin, tmin, tmin);
		send_elem(6'd0, 6'd0);
		send_elem(6'd63, 6'd63);
		send_elem(6'd21, 6'd42);
		drain();
		set_target(tmin, tmax, 30'd0);
		send_elem(6'd63, 6'd0);
		send_elem(6'd0, 6'd63);
		drain();
		// target on an element: zero distance, phase zero
		set_target(30'd4096, 30'd8192, 30'd0);
		send_elem(6'd4, 6'd2);
		drain();
		// exact quarter turns of distance
		set_target(30'd1024, 30'd0, 30'd0);
		send_elem(6'd0, 6'd0);
		drain();
		set_target(30'd0, 30'd0, 30'd2048);
		send_elem(6'd0, 6'd0);
		drain();
		set_target(30'd0, 30'd0, 30'h3FFF_F400);  // -3072
		send_elem(6'd0, 6'd0);
		drain();
	endtask

	// random elements under a series of random targets
	task automatic test_random_elements();
		logic [29:0] x, y, z;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph % 2 == 0) begin
				x = 30'($urandom());
				y = 30'($urandom());
				z = 30'($urandom());
			end else begin
				// near-field target over the array
				x = 30'($urandom_range(0, 140000));
				y = 30'($urandom_range(0, 140000));
				z = 30'($urandom_range(0, 60000));
			end
			set_target(x, y, z);
			gaps_on = (ph != 3);
			for (int i = 0; i < 85; i++)
				send_elem(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
			drain();
		end
		gaps_on = 1'b1;
	endtask

	// long receiver hold-off while words keep coming
	task automatic test_backpressure();
		set_target(30'd70000, 30'h3FFF_0000, 30'd30000);
		hold_request = 300;
		gaps_on = 1'b0;
		for (int i = 0; i < 80; i++)
			send_elem(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
		gaps_on = 1'b1;
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_target();
		test_extreme_targets();
		test_random_elements();
		test_backpressure();
		$display("Covered %0d element words, %0d results, %0d target writes,", n_sent,
			n_checked, n_cfg);
		$display("extreme and random targets, random gaps and a long output hold-off.");
		if (n_errors == 0 && pending_weights.size() == 0) begin
			$display("near_field_beam_phase_generator_top verification clean");
		end else begin
			$display("near_field_beam_phase_generator_top verification failed");
		end
		$finish;
	end

endmodule
